[rtl/raycast_wall_column_texturer_core_macros.svh]
// Assertion macros for the raycast wall column texturer.
// No dependencies; included by the top level only.
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_CORE_MACROS_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RCWT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCWT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCWT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RCWT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/rcwt_pkg.sv]
// Shared types and constants of the raycast wall column texturer.
// No dependencies.
package rcwt_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_SCREEN_HEIGHT_DEF = 2048;
  localparam int MAX_TEXTURE_SIZE_DEF = 1024;

  localparam int POS_W = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ROW = 1'b1;

  localparam logic [1:0] KIND_CEILING = 2'd0;
  localparam logic [1:0] KIND_TEXEL = 2'd1;
  localparam logic [1:0] KIND_FLOOR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORTH_TEX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH_TEX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EAST_TEX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEST_TEX = 3'd6;

  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [23:0] CEILING_COLOR_RST = 24'h87C5D6;
  localparam logic [23:0] FLOOR_COLOR_RST = 24'h7D7D7D;
  localparam logic [10:0] TEX_HEIGHT_RST = 11'd64;

  typedef struct packed {
    logic        op;
    logic [11:0] screen_column;
    logic [31:0] wall_distance;
    logic [1:0]  wall_side;
    logic [9:0]  texture_column;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_column;
    logic [10:0] pixel_row;
    logic [1:0]  pixel_kind;
    logic [23:0] fill_color;
    logic [1:0]  texture_pick;
    logic [9:0]  texel_row;
    logic [9:0]  texel_column;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic load_col;
    logic div_step;
    logic geom_load;
    logic step_load;
    logic pos_load;
    logic row_go;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } dp_status_t;
endpackage

[rtl/rcwt_ctrl.sv]
// Sequencer of the column start and the row handshake.
// Depends on rcwt_pkg.
module rcwt_ctrl import rcwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output logic       idle_o,
  output ctrl_cmd_t  cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVH = 3'd1;
  localparam logic [2:0] S_GEOM = 3'd2;
  localparam logic [2:0] S_DIVT = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_POS  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign idle_o = (state_q == S_IDLE);
  assign in_ready_o = idle_o && !status_i.out_busy;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_op_i == OP_START) begin
          cmd_o.load_col = 1'b1;
          state_d = S_DIVH;
        end else if (accept) begin
          cmd_o.row_go = 1'b1;
        end
      end
      S_DIVH: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_GEOM;
      end
      S_GEOM: begin
        cmd_o.geom_load = 1'b1;
        state_d = S_DIVT;
      end
      S_DIVT: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.step_load = 1'b1;
        state_d = S_POS;
      end
      S_POS: begin
        cmd_o.pos_load = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[rtl/rcwt_datapath.sv]
// Configuration registers, serial divider, column geometry and pixel output register.
// Depends on rcwt_pkg.
module rcwt_datapath import rcwt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_SCREEN_HEIGHT = MAX_SCREEN_HEIGHT_DEF,
  parameter int MAX_TEXTURE_SIZE = MAX_TEXTURE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  input  ctrl_cmd_t             cmd_i,
  input  logic                  out_ready_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  output out_item_t             out_data_o
);
  localparam int HW = $clog2(MAX_SCREEN_HEIGHT + 1);
  localparam int TW = $clog2(MAX_TEXTURE_SIZE + 1);
  localparam int DWH = HW + FRAC_BITS;
  localparam int DWT = TW + FRAC_BITS;
  localparam int DW = (DWH > DWT) ? DWH : DWT;
  localparam int CNT_W = $clog2(DW);
  localparam int SW = ((HW > 16) ? HW : 16) + 1;
  localparam int TR_W = POS_W - FRAC_BITS;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  logic [11:0] screen_q;
  logic [23:0] ceil_q, floor_q;
  logic [10:0] tex_q [4];

  logic [DW-1:0]    shift_q;
  logic [31:0]      rem_q, dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic [32:0]      trial;
  logic             qbit;

  logic             active_q;
  logic [15:0]      wall_height_q;
  logic [HW-1:0]    top_q, bot_q;
  logic [14:0]      offset_q;
  logic [POS_W-1:0] step_q, pos_q;
  logic [10:0]      row_q;
  logic [1:0]       side_q;
  logic [9:0]       tcol_q;
  logic [11:0]      scol_q;
  logic             zero_dist_q;

  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        pix_d;

  logic [HW-1:0]    h_eff;
  logic [TW-1:0]    t_eff;
  logic [10:0]      t_raw;
  logic [15:0]      lh_c;
  logic [14:0]      half_l;
  logic [HW-1:0]    half_h;
  logic [SW-1:0]    bot_sum;
  logic [40:0]      prod;
  logic [POS_W:0]   pos_sum;
  logic [TR_W-1:0]  tr_raw;
  logic [31:0]      tr_c;
  logic             last_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q <= SCREEN_HEIGHT_RST;
      ceil_q <= CEILING_COLOR_RST;
      floor_q <= FLOOR_COLOR_RST;
      tex_q[0] <= TEX_HEIGHT_RST;
      tex_q[1] <= TEX_HEIGHT_RST;
      tex_q[2] <= TEX_HEIGHT_RST;
      tex_q[3] <= TEX_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_HEIGHT: screen_q <= cfg_data_i[11:0];
        REG_CEILING_COLOR: ceil_q <= cfg_data_i;
        REG_FLOOR_COLOR: floor_q <= cfg_data_i;
        REG_NORTH_TEX: tex_q[0] <= cfg_data_i[10:0];
        REG_SOUTH_TEX: tex_q[1] <= cfg_data_i[10:0];
        REG_EAST_TEX: tex_q[2] <= cfg_data_i[10:0];
        REG_WEST_TEX: tex_q[3] <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (screen_q == 12'd0) h_eff = HW'(1);
    else if ({20'd0, screen_q} > 32'(MAX_SCREEN_HEIGHT)) h_eff = HW'(MAX_SCREEN_HEIGHT);
    else h_eff = HW'(screen_q);
    t_raw = tex_q[side_q];
    if (t_raw == 11'd0) t_eff = TW'(1);
    else if ({21'd0, t_raw} > 32'(MAX_TEXTURE_SIZE)) t_eff = TW'(MAX_TEXTURE_SIZE);
    else t_eff = TW'(t_raw);
  end

  assign trial = {rem_q, shift_q[DW-1]};
  assign qbit = (trial >= {1'b0, dsr_q});
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    if (zero_dist_q || {{(64-DW){1'b0}}, shift_q} > 64'd65535) lh_c = 16'hFFFF;
    else lh_c = 16'(shift_q);
    half_l = lh_c[15:1];
    half_h = h_eff >> 1;
    bot_sum = SW'(half_l) + SW'(half_h);
  end

  assign prod = {26'd0, offset_q} * {15'd0, step_q};
  assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
  assign tr_raw = pos_q[POS_W-1:FRAC_BITS];
  assign last_c = ({21'd0, row_q} >= (32'(h_eff) - 32'd1));

  always_comb begin
    if (32'(tr_raw) > (32'(t_eff) - 32'd1)) tr_c = 32'(t_eff) - 32'd1;
    else tr_c = 32'(tr_raw);
  end

  always_comb begin
    pix_d = '0;
    pix_d.pixel_column = scol_q;
    pix_d.pixel_row = row_q;
    pix_d.last_row = last_c;
    if ({21'd0, row_q} < 32'(top_q)) begin
      pix_d.pixel_kind = KIND_CEILING;
      pix_d.fill_color = ceil_q;
    end else if ({21'd0, row_q} < 32'(bot_q)) begin
      pix_d.pixel_kind = KIND_TEXEL;
      pix_d.texture_pick = side_q;
      pix_d.texel_row = tr_c[9:0];
      pix_d.texel_column = tcol_q;
    end else begin
      pix_d.pixel_kind = KIND_FLOOR;
      pix_d.fill_color = floor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_col) begin
      shift_q <= DW'({h_eff, {FRAC_BITS{1'b0}}});
      dsr_q <= in_data_i.wall_distance;
      zero_dist_q <= (in_data_i.wall_distance == 32'd0);
      rem_q <= '0;
      cnt_q <= CNT_W'(DW - 1);
      scol_q <= in_data_i.screen_column;
      side_q <= in_data_i.wall_side;
      tcol_q <= in_data_i.texture_column;
    end else if (cmd_i.geom_load) begin
      wall_height_q <= lh_c;
      top_q <= (half_l >= 15'(half_h)) ? '0 : HW'(half_h - HW'(half_l));
      bot_q <= (bot_sum >= SW'(h_eff)) ? HW'(h_eff - HW'(1)) : HW'(bot_sum);
      offset_q <= (half_l >= 15'(half_h)) ? 15'(half_l - 15'(half_h)) : 15'd0;
      shift_q <= DW'({t_eff, {FRAC_BITS{1'b0}}});
      dsr_q <= {16'd0, lh_c};
      rem_q <= '0;
      cnt_q <= CNT_W'(DW - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
      shift_q <= {shift_q[DW-2:0], qbit};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.step_load) begin
      if (wall_height_q == 16'd0) step_q <= '0;
      else if ({{(64-DW){1'b0}}, shift_q} > 64'(POS_MAX)) step_q <= POS_MAX;
      else step_q <= POS_W'(shift_q);
    end
    if (cmd_i.pos_load) begin
      pos_q <= (prod > 41'(POS_MAX)) ? POS_MAX : prod[POS_W-1:0];
      row_q <= '0;
    end else if (cmd_i.row_go && active_q) begin
      if ({21'd0, row_q} >= 32'(top_q) && {21'd0, row_q} < 32'(bot_q)) begin
        pos_q <= pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
      end
      if (!last_c) row_q <= row_q + 11'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.pos_load) active_q <= 1'b1;
      else if (cmd_i.row_go && active_q && last_c) active_q <= 1'b0;
      if (cmd_i.row_go && active_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_go && active_q) begin
      out_q <= pix_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule

[rtl/raycast_wall_column_texturer_core.sv]
// Top level of the raycast wall column texturer.
// Depends on rcwt_pkg, rcwt_ctrl, rcwt_datapath and the assertion macro header.
//
// Input beats carry either a column start or a row request; output beats carry
// one pixel each. Both channels use valid/ready. A column start gives no
// output; it runs two restoring divisions on a shared one-bit-per-cycle
// divider of DW = max(HW, TW) + FRAC_BITS bits, with the geometry state
// between the two divisions and the step and multiply states after them;
// until the column start is through, no input beat is taken.
// A row request is taken and its pixel appears in the output
// register on the next cycle, so rows stream at one per cycle while the
// receiver keeps up. A row request with no active column yields nothing.
// When the receiver stalls, the pixel holds in the output register and the
// next input beat waits until it is taken.
// Reset restores the register defaults (480 rows, default colors, texture
// heights of 64) and ends any active column. Configuration writes take
// effect at once and are meant for idle periods.
`include "raycast_wall_column_texturer_core_macros.svh"
module raycast_wall_column_texturer_core import rcwt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_SCREEN_HEIGHT = MAX_SCREEN_HEIGHT_DEF,
  parameter int MAX_TEXTURE_SIZE = MAX_TEXTURE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       idle;

  rcwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .idle_o     (idle),
    .cmd_o      (cmd)
  );

  rcwt_datapath #(
    .FRAC_BITS         (FRAC_BITS),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT),
    .MAX_TEXTURE_SIZE  (MAX_TEXTURE_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `RCWT_ASSERT(a_start_blocks, clk_i, rst_ni, (in_valid_i && in_ready_o && in_data_i.op == OP_START) |=> !in_ready_o, "input taken during column setup")
  `RCWT_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> idle, "ready outside idle")
  `RCWT_ASSERT(a_kind_valid, clk_i, rst_ni, out_valid_o |-> (out_data_o.pixel_kind != 2'd3), "bad pixel kind")
  `RCWT_ASSERT(a_texel_fill, clk_i, rst_ni, (out_valid_o && out_data_o.pixel_kind == KIND_TEXEL) |-> (out_data_o.fill_color == 24'd0), "texel with fill color")
endmodule
